// File: hw/rtl/dcfam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcfam_pkg;

    typedef enum logic [2:0] {
        ST_HEADER   = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_PAYLOAD  = 3'd2,
        ST_READY    = 3'd3,
        ST_TRANSMIT = 3'd4
    } asm_state_t;

    localparam logic [7:0] HEADER_RESET      = 8'hD3;
    localparam logic [2:0] ADDR_FRAME_HEADER = 3'd0;
    localparam int         TRAILER_EXTRA     = 3;
    localparam int         SUM_W             = 10;
    localparam int         QUEUE_DEPTH       = 4;

    typedef struct packed {
        logic       chan;
        logic       in_range;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } poll_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
        asm_state_t channel_state;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/dcfam_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dcfam_front #(
    parameter int CHANNELS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            channel_index,
    input  wire logic            rx_valid,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            tx_ready,
    output logic                 q_valid,
    output dcfam_pkg::poll_t     q_item,
    input  wire logic            q_pop
);

    localparam int QAW = $clog2(dcfam_pkg::QUEUE_DEPTH);

    dcfam_pkg::poll_t slot_reg [dcfam_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]   wr_reg;
    logic [QAW-1:0]   wr_next;
    logic [QAW-1:0]   rd_reg;
    logic [QAW-1:0]   rd_next;
    logic [QAW:0]     cnt_reg;
    logic [QAW:0]     cnt_next;
    logic             push;
    dcfam_pkg::poll_t item;

    always_comb
    begin
        item.chan     = channel_index;
        item.in_range = (32'(channel_index) < CHANNELS);
        item.rx_valid = rx_valid;
        item.rx_byte  = rx_byte;
        item.tx_ready = tx_ready;
    end

    assign in_stall = (cnt_reg == (QAW + 1)'(dcfam_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + QAW'(1) : wr_reg;
        rd_next  = q_pop ? rd_reg + QAW'(1) : rd_reg;
        cnt_next = cnt_reg + (QAW + 1)'(push) - (QAW + 1)'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dcfam_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dcfam_back #(
    parameter int CHANNELS,
    parameter int RX_DEPTH,
    parameter int FRAME_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        frame_header,
    input  wire logic              q_valid,
    input  wire dcfam_pkg::poll_t  q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output dcfam_pkg::result_t     out_res
);

    localparam int CW           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NCH          = 1 << CW;
    localparam int RAW          = $clog2(RX_DEPTH);
    localparam int RCW          = $clog2(RX_DEPTH + 1);
    localparam int FAW          = $clog2(FRAME_DEPTH);
    localparam int FCW          = $clog2(FRAME_DEPTH + 1);
    localparam int BW           = FCW;
    localparam int RX_MEM_DEPTH = 1 << (CW + RAW);
    localparam int FR_MEM_DEPTH = 1 << (CW + FAW);

    localparam logic [RAW-1:0] RX_LAST  = RAW'(RX_DEPTH - 1);
    localparam logic [FAW-1:0] FR_LAST  = FAW'(FRAME_DEPTH - 1);
    localparam logic [RCW-1:0] RX_FULL  = RCW'(RX_DEPTH);
    localparam logic [FCW-1:0] FR_FULL  = FCW'(FRAME_DEPTH);
    localparam logic [BW-1:0]  BC_LIMIT = BW'(FRAME_DEPTH);

    function automatic logic [RAW-1:0] rx_adv(input logic [RAW-1:0] p);
        return (p == RX_LAST) ? '0 : p + RAW'(1);
    endfunction

    function automatic logic [FAW-1:0] fr_adv(input logic [FAW-1:0] p);
        return (p == FR_LAST) ? '0 : p + FAW'(1);
    endfunction

    logic [7:0] rx_mem [RX_MEM_DEPTH];
    logic [7:0] fr_mem [FR_MEM_DEPTH];

    logic [RAW-1:0]        rx_rd_reg  [NCH];
    logic [RAW-1:0]        rx_wr_reg  [NCH];
    logic [RCW-1:0]        rx_cnt_reg [NCH];
    logic [FAW-1:0]        fr_rd_reg  [NCH];
    logic [FAW-1:0]        fr_wr_reg  [NCH];
    logic [FCW-1:0]        fr_cnt_reg [NCH];
    dcfam_pkg::asm_state_t st_reg     [NCH];
    logic [BW-1:0]         bc_reg     [NCH];

    logic                  x_valid_reg;
    logic                  x_valid_next;
    dcfam_pkg::poll_t      x_item_reg;
    logic [7:0]            rx_q0_reg;
    logic [7:0]            rx_q1_reg;
    logic [7:0]            fr_q0_reg;
    logic [7:0]            fr_q1_reg;
    logic                  rx_sel1_reg;
    logic                  rx_sel1_next;
    logic                  rx_byp_reg;
    logic                  rx_byp_next;
    logic [7:0]            rx_byp_byte_reg;
    logic                  fr_sel1_reg;
    logic                  fr_sel1_next;
    logic                  fr_byp_reg;
    logic                  fr_byp_next;
    logic [7:0]            fr_byp_byte_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    dcfam_pkg::result_t    out_res_reg;
    dcfam_pkg::result_t    out_res_next;

    logic [RAW-1:0]        rx_rd_next;
    logic [RAW-1:0]        rx_wr_next;
    logic [RCW-1:0]        rx_cnt_next;
    logic [FAW-1:0]        fr_rd_next;
    logic [FAW-1:0]        fr_wr_next;
    logic [FCW-1:0]        fr_cnt_next;
    dcfam_pkg::asm_state_t st_next;
    logic [BW-1:0]         bc_next;

    logic [CW-1:0]         cx;
    logic [CW-1:0]         cq;
    logic                  exec_fire;
    logic                  upd;
    logic [RAW-1:0]        rx_rd;
    logic [RAW-1:0]        rx_wr;
    logic [RCW-1:0]        rx_cnt;
    logic [FAW-1:0]        fr_rd;
    logic [FAW-1:0]        fr_wr;
    logic [FCW-1:0]        fr_cnt;
    dcfam_pkg::asm_state_t st_cur;
    logic [BW-1:0]         bc_cur;
    logic                  push_ok;
    logic                  dropped;
    logic                  rx_have;
    logic [7:0]            rx_head;
    logic                  rx_pop;
    logic                  fr_push_ok;
    logic                  fr_have;
    logic                  tx_pop;
    logic [7:0]            fr_head;
    logic                  busy;
    logic [RAW-1:0]        rq0;
    logic [RAW-1:0]        rq1;
    logic [FAW-1:0]        fq0;
    logic [FAW-1:0]        fq1;
    logic                  same_ch;

    assign cx        = CW'(x_item_reg.chan);
    assign cq        = CW'(q_item.chan);
    assign exec_fire = x_valid_reg && (!out_valid_reg || !out_stall);
    assign upd       = exec_fire && x_item_reg.in_range;
    assign q_pop     = q_valid && (!x_valid_reg || exec_fire);

    assign rx_rd  = rx_rd_reg[cx];
    assign rx_wr  = rx_wr_reg[cx];
    assign rx_cnt = rx_cnt_reg[cx];
    assign fr_rd  = fr_rd_reg[cx];
    assign fr_wr  = fr_wr_reg[cx];
    assign fr_cnt = fr_cnt_reg[cx];
    assign st_cur = st_reg[cx];
    assign bc_cur = bc_reg[cx];

    assign push_ok = x_item_reg.rx_valid && (rx_cnt != RX_FULL);
    assign dropped = x_item_reg.rx_valid && !push_ok;
    assign rx_have = (rx_cnt != '0) || push_ok;
    assign rx_head = (rx_cnt == '0) ? x_item_reg.rx_byte :
                     rx_byp_reg     ? rx_byp_byte_reg :
                     rx_sel1_reg    ? rx_q1_reg : rx_q0_reg;

    always_comb
    begin
        busy = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (st_reg[i] == dcfam_pkg::ST_TRANSMIT)
            begin
                busy = 1'b1;
            end
        end
    end

    // assembly fsm: next state and count
    always_comb
    begin
        logic [BW-1:0]               bc_inc;
        logic [BW-1:0]               bc_dec;
        logic [dcfam_pkg::SUM_W-1:0] len_sum;
        bc_inc  = bc_cur + BW'(1);
        bc_dec  = (bc_cur != '0) ? bc_cur - BW'(1) : '0;
        len_sum = dcfam_pkg::SUM_W'(bc_inc) + dcfam_pkg::SUM_W'(rx_head)
                  + dcfam_pkg::SUM_W'(2);
        st_next = st_cur;
        bc_next = bc_cur;
        case (st_cur)
            dcfam_pkg::ST_HEADER:
            begin
                if (rx_have)
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= BC_LIMIT)
                    begin
                        st_next = dcfam_pkg::ST_TRANSMIT;
                    end
                    else if (rx_head == frame_header)
                    begin
                        st_next = dcfam_pkg::ST_LENGTH;
                    end
                end
            end
            dcfam_pkg::ST_LENGTH:
            begin
                if (rx_have)
                begin
                    if (len_sum >= dcfam_pkg::SUM_W'(FRAME_DEPTH))
                    begin
                        st_next = dcfam_pkg::ST_TRANSMIT;
                        bc_next = bc_inc;
                    end
                    else
                    begin
                        st_next = dcfam_pkg::ST_PAYLOAD;
                        bc_next = BW'(rx_head) + BW'(dcfam_pkg::TRAILER_EXTRA);
                    end
                end
            end
            dcfam_pkg::ST_PAYLOAD:
            begin
                if (rx_have)
                begin
                    bc_next = bc_dec;
                    if (bc_dec == '0)
                    begin
                        st_next = dcfam_pkg::ST_READY;
                    end
                end
            end
            dcfam_pkg::ST_READY:
            begin
                bc_next = '0;
                if (!busy)
                begin
                    st_next = dcfam_pkg::ST_TRANSMIT;
                end
            end
            dcfam_pkg::ST_TRANSMIT:
            begin
                if (fr_cnt == '0)
                begin
                    st_next = dcfam_pkg::ST_HEADER;
                    bc_next = '0;
                end
            end
            default:
            begin
                st_next = dcfam_pkg::ST_HEADER;
                bc_next = '0;
            end
        endcase
    end

    // assembly fsm: byte move
    always_comb
    begin
        case (st_cur)
            dcfam_pkg::ST_HEADER,
            dcfam_pkg::ST_LENGTH,
            dcfam_pkg::ST_PAYLOAD: rx_pop = rx_have;
            default:               rx_pop = 1'b0;
        endcase
    end

    assign fr_push_ok = rx_pop && (fr_cnt != FR_FULL);
    assign fr_have    = (fr_cnt != '0) || fr_push_ok;
    assign tx_pop     = (st_next == dcfam_pkg::ST_TRANSMIT) && x_item_reg.tx_ready && fr_have;
    assign fr_head    = (fr_cnt == '0) ? rx_head :
                        fr_byp_reg     ? fr_byp_byte_reg :
                        fr_sel1_reg    ? fr_q1_reg : fr_q0_reg;

    always_comb
    begin
        rx_rd_next  = rx_pop ? rx_adv(rx_rd) : rx_rd;
        rx_wr_next  = push_ok ? rx_adv(rx_wr) : rx_wr;
        rx_cnt_next = rx_cnt + RCW'(push_ok) - RCW'(rx_pop);
        fr_rd_next  = tx_pop ? fr_adv(fr_rd) : fr_rd;
        fr_wr_next  = fr_push_ok ? fr_adv(fr_wr) : fr_wr;
        fr_cnt_next = fr_cnt + FCW'(fr_push_ok) - FCW'(tx_pop);
    end

    // prefetch heads for the next word, corrected for the word executing now
    always_comb
    begin
        rq0          = rx_rd_reg[cq];
        rq1          = rx_adv(rq0);
        fq0          = fr_rd_reg[cq];
        fq1          = fr_adv(fq0);
        same_ch      = upd && (cx == cq);
        rx_sel1_next = same_ch && rx_pop;
        rx_byp_next  = same_ch && push_ok && (rx_wr == (rx_sel1_next ? rq1 : rq0));
        fr_sel1_next = same_ch && tx_pop;
        fr_byp_next  = same_ch && fr_push_ok && (fr_wr == (fr_sel1_next ? fq1 : fq0));
    end

    always_comb
    begin
        out_res_next = '0;
        if (x_item_reg.in_range)
        begin
            out_res_next.tx_valid      = tx_pop;
            out_res_next.tx_byte       = tx_pop ? fr_head : 8'd0;
            out_res_next.rx_dropped    = dropped;
            out_res_next.channel_state = st_next;
        end
        else
        begin
            out_res_next.channel_state = dcfam_pkg::ST_HEADER;
        end
    end

    assign x_valid_next   = q_pop ? 1'b1 : (exec_fire ? 1'b0 : x_valid_reg);
    assign out_valid_next = exec_fire ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk)
    begin
        if (upd && push_ok)
        begin
            rx_mem[{cx, rx_wr}] <= x_item_reg.rx_byte;
        end
        if (q_pop)
        begin
            rx_q0_reg <= rx_mem[{cq, rq0}];
            rx_q1_reg <= rx_mem[{cq, rq1}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd && fr_push_ok)
        begin
            fr_mem[{cx, fr_wr}] <= rx_head;
        end
        if (q_pop)
        begin
            fr_q0_reg <= fr_mem[{cq, fq0}];
            fr_q1_reg <= fr_mem[{cq, fq1}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            x_item_reg      <= q_item;
            rx_sel1_reg     <= rx_sel1_next;
            rx_byp_reg      <= rx_byp_next;
            rx_byp_byte_reg <= x_item_reg.rx_byte;
            fr_sel1_reg     <= fr_sel1_next;
            fr_byp_reg      <= fr_byp_next;
            fr_byp_byte_reg <= rx_head;
        end
        if (exec_fire)
        begin
            out_res_reg <= out_res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                rx_rd_reg[i]  <= '0;
                rx_wr_reg[i]  <= '0;
                rx_cnt_reg[i] <= '0;
                fr_rd_reg[i]  <= '0;
                fr_wr_reg[i]  <= '0;
                fr_cnt_reg[i] <= '0;
                st_reg[i]     <= dcfam_pkg::ST_HEADER;
                bc_reg[i]     <= '0;
            end
        end
        else
        begin
            x_valid_reg   <= x_valid_next;
            out_valid_reg <= out_valid_next;
            if (upd)
            begin
                rx_rd_reg[cx]  <= rx_rd_next;
                rx_wr_reg[cx]  <= rx_wr_next;
                rx_cnt_reg[cx] <= rx_cnt_next;
                fr_rd_reg[cx]  <= fr_rd_next;
                fr_wr_reg[cx]  <= fr_wr_next;
                fr_cnt_reg[cx] <= fr_cnt_next;
                st_reg[cx]     <= st_next;
                bc_reg[cx]     <= bc_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_x_hold: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid_reg && !exec_fire |=> x_valid_reg && $stable(x_item_reg))
        else $error("executing word changed while held");

    a_rx_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid_reg && (rx_cnt_reg[cx] == '0) |-> (rx_wr_reg[cx] == rx_rd_reg[cx]))
        else $error("receive queue empty with unequal pointers");

    a_fr_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid_reg && (fr_cnt_reg[cx] == '0) |-> (fr_wr_reg[cx] == fr_rd_reg[cx]))
        else $error("frame queue empty with unequal pointers");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid_reg && (st_reg[cx] == dcfam_pkg::ST_PAYLOAD) |-> (bc_reg[cx] < BC_LIMIT))
        else $error("payload count beyond frame size");

    a_tx_in_transmit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.tx_valid
        |-> (out_res_reg.channel_state == dcfam_pkg::ST_TRANSMIT))
        else $error("byte sent outside transmit");

endmodule

`default_nettype wire

// File: hw/rtl/dual_channel_frame_assembler_mux.sv
`timescale 1ns / 1ps
`default_nettype none

// A poll word goes through the front queue and the execute register; its result
// word is held in the output register. One poll word per cycle while out_stall is
// low. Rx and frame heads are read from memory at pop, forwarded from the word in flight.
// Reset (rst_n, asynchronous, low): all queues empty, every channel in header search,
// counts zero, frame header 0xD3. No clearing pass; polls are taken right after reset.

module dual_channel_frame_assembler_mux #(
    parameter int CHANNELS    = 2,
    parameter int RX_DEPTH    = 1024,
    parameter int FRAME_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        channel_index,
    input  wire logic        rx_valid,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        tx_ready,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             rx_dropped,
    output logic [2:0]       channel_state
);

    logic [7:0]         frame_header_reg;
    logic [7:0]         frame_header_next;
    logic               hdr_write;
    logic               q_valid;
    dcfam_pkg::poll_t   q_item;
    logic               q_pop;
    dcfam_pkg::result_t out_res;

    assign pready    = 1'b1;
    assign hdr_write = psel && penable && pwrite && (paddr == dcfam_pkg::ADDR_FRAME_HEADER);
    assign frame_header_next = hdr_write ? pwdata[7:0] : frame_header_reg;
    assign prdata    = (paddr == dcfam_pkg::ADDR_FRAME_HEADER) ? {24'd0, frame_header_reg}
                                                               : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_header_reg <= dcfam_pkg::HEADER_RESET;
        end
        else
        begin
            frame_header_reg <= frame_header_next;
        end
    end

    dcfam_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .channel_index (channel_index),
        .rx_valid      (rx_valid),
        .rx_byte       (rx_byte),
        .tx_ready      (tx_ready),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    dcfam_back #(
        .CHANNELS    (CHANNELS),
        .RX_DEPTH    (RX_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_header (frame_header_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_res      (out_res)
    );

    assign tx_valid      = out_res.tx_valid;
    assign tx_byte       = out_res.tx_byte;
    assign rx_dropped    = out_res.rx_dropped;
    assign channel_state = out_res.channel_state;

endmodule

`default_nettype wire
